>>> hdl/rotating_color_key_blitter_assert.svh
// assertion macros shared by the blitter rtl
`ifndef ROTATING_COLOR_KEY_BLITTER_ASSERT_SVH
`define ROTATING_COLOR_KEY_BLITTER_ASSERT_SVH

`ifndef SYNTHESIS
`define RCKB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rckb assertion failed");
`define RCKB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rckb assertion failed");
`else
`define RCKB_ASSERT(lbl, clk, rst_n, prop)
`define RCKB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/rckb_pkg.sv
`default_nettype none

package rckb_pkg;

    localparam int SIDE_MAX  = 256;
    localparam int SIDE_W    = $clog2(SIDE_MAX) + 1;
    localparam int COORD_W   = $clog2(SIDE_MAX);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int MEM_DEPTH = SIDE_MAX * SIDE_MAX;
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int PIX_W     = 16;
    localparam int SCR_W     = 16;
    localparam int ROT_W     = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMG_WIDTH  = 4'd0,
        CFG_IMG_HEIGHT = 4'd1,
        CFG_ROTATION   = 4'd2,
        CFG_KEY_ENABLE = 4'd3,
        CFG_KEY_COLOR  = 4'd4,
        CFG_BACK_COLOR = 4'd5,
        CFG_DEST_X     = 4'd6,
        CFG_DEST_Y     = 4'd7
    } cfg_index_t;

    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(SIDE_MAX)) begin
            r = SIDE_W'(SIDE_MAX);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rotating_color_key_blitter.sv
// Rotating color-key blitter.
// Input channel s_*: each item is a load (s_tuser = 0) carrying one source pixel
// in s_tdata, or a fetch (s_tuser = 1). Loads fill the image store in source
// row order until width x height pixels have arrived; further loads are dropped.
// Each fetch after a full load emits one pixel of the rotated image on m_*,
// with screen coordinates and m_tlast on the final pixel, after which the block
// returns to loading. Fetches before the load is complete give no item.
// Configuration is written on the cfg_* channel (index, data), always ready.
// Flow: loads are taken back to back while idle. A fetch passes through the
// address product and the synchronous store read, then the output register.
// The emit state holds the input off until the output register takes the result.
// Reset (aresetn low, synchronous) returns to the loading phase with registers
// at width 1, height 1, everything else zero; the store and data registers are not cleared.
// While m_tready is low a result waits in the output register; the block still
// takes loads, early fetches and one more real fetch, then holds its input off
// until the slot frees.
`default_nettype none

module rotating_color_key_blitter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rckb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rckb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rckb_pkg::PIX_W-1:0]       s_tdata,  // pixel_in
    input  wire logic                             s_tuser,  // func
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [2*rckb_pkg::SCR_W+rckb_pkg::PIX_W-1:0] m_tdata, // screen_x, screen_y, pixel_out
    output logic                                  m_tlast   // last_pixel
);

    localparam int SW = rckb_pkg::SIDE_W;
    localparam int CW = rckb_pkg::COORD_W;
    localparam int AW = rckb_pkg::ADDR_W;
    localparam int NW = rckb_pkg::COUNT_W;
    localparam int PW = rckb_pkg::PIX_W;
    localparam int XW = rckb_pkg::SCR_W;

    // configuration registers
    logic [SW-1:0]            img_width_reg, img_height_reg;
    rckb_pkg::rot_t           rotation_reg;
    logic                     key_enable_reg;
    logic [PW-1:0]            key_color_reg, back_color_reg;
    logic [XW-1:0]            dest_x_reg, dest_y_reg;

    // scan state
    logic [NW-1:0]            load_count_reg, load_count_next;
    logic [CW-1:0]            out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic                     image_ready_reg, image_ready_next;
    rckb_pkg::state_t         state_reg, state_next;

    // fetch in flight
    logic [XW-1:0]            fx_reg, fy_reg;
    logic                     flast_reg;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic [PW-1:0]            m_pix_reg;
    logic [XW-1:0]            m_x_reg, m_y_reg;
    logic                     m_last_reg;

    // pixel store
    logic [PW-1:0]            mem [rckb_pkg::MEM_DEPTH];
    logic [PW-1:0]            rd_data_reg;

    logic [SW-1:0]            w_eff, h_eff;
    logic [CW-1:0]            w_m1, h_m1, rows_m1, cols_m1, src_r, src_c;
    logic [NW-1:0]            total, prod, load_inc;
    logic [AW-1:0]            rd_addr;
    logic                     in_fire, is_load, is_fetch, do_load, do_fetch, last_px;
    logic                     slot_free, cfg_fire;
    logic [PW-1:0]            pix_keyed;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign is_load   = s_tuser == rckb_pkg::FUNC_LOAD;
    assign is_fetch  = s_tuser == rckb_pkg::FUNC_FETCH;
    assign slot_free = !m_valid_reg || m_tready;

    assign w_eff    = rckb_pkg::clamp_side(img_width_reg);
    assign h_eff    = rckb_pkg::clamp_side(img_height_reg);
    assign w_m1     = CW'(w_eff - SW'(1));
    assign h_m1     = CW'(h_eff - SW'(1));
    assign total    = NW'(w_eff) * NW'(h_eff);
    assign load_inc = load_count_reg + NW'(1);

    always_comb begin
        rows_m1 = h_m1;
        cols_m1 = w_m1;
        src_r   = out_row_reg;
        src_c   = out_col_reg;
        unique case (rotation_reg)
            rckb_pkg::ROT_90: begin
                rows_m1 = w_m1;
                cols_m1 = h_m1;
                src_r   = h_m1 - out_col_reg;
                src_c   = out_row_reg;
            end
            rckb_pkg::ROT_180: begin
                src_r = h_m1 - out_row_reg;
                src_c = w_m1 - out_col_reg;
            end
            rckb_pkg::ROT_270: begin
                rows_m1 = w_m1;
                cols_m1 = h_m1;
                src_r   = out_col_reg;
                src_c   = w_m1 - out_row_reg;
            end
            default: begin
            end
        endcase
    end

    assign prod    = NW'(src_r) * NW'(w_eff);
    assign rd_addr = AW'(prod + NW'(src_c));
    assign last_px = (out_row_reg == rows_m1) && (out_col_reg == cols_m1);

    assign do_load  = in_fire && is_load && !image_ready_reg && (load_count_reg < total);
    assign do_fetch = in_fire && is_fetch && image_ready_reg;

    // control: state, scan counters, output valid
    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        load_count_next  = load_count_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        image_ready_next = image_ready_reg;
        m_valid_next     = m_valid_reg && !m_tready;

        unique case (state_reg)
            rckb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (do_load) begin
                    load_count_next = load_inc;
                    if (load_inc >= total) begin
                        image_ready_next = 1'b1;
                    end
                end
                if (do_fetch) begin
                    state_next = rckb_pkg::ST_EMIT;
                    if (last_px) begin
                        load_count_next  = '0;
                        out_row_next     = '0;
                        out_col_next     = '0;
                        image_ready_next = 1'b0;
                    end else if (out_col_reg == cols_m1) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + CW'(1);
                    end else begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                end
            end
            rckb_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    state_next   = rckb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rckb_pkg::ST_IDLE;
            end
        endcase

        if (cfg_fire) begin
            if (cfg_index == rckb_pkg::CFG_IMG_WIDTH || cfg_index == rckb_pkg::CFG_IMG_HEIGHT) begin
                load_count_next  = '0;
                out_row_next     = '0;
                out_col_next     = '0;
                image_ready_next = 1'b0;
            end else if (cfg_index == rckb_pkg::CFG_ROTATION) begin
                out_row_next = '0;
                out_col_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rckb_pkg::ST_IDLE;
            load_count_reg  <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            image_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            out_row_reg     <= out_row_next;
            out_col_reg     <= out_col_next;
            image_ready_reg <= image_ready_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg  <= SW'(1);
            img_height_reg <= SW'(1);
            rotation_reg   <= rckb_pkg::ROT_0;
            key_enable_reg <= 1'b0;
            key_color_reg  <= '0;
            back_color_reg <= '0;
            dest_x_reg     <= '0;
            dest_y_reg     <= '0;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                rckb_pkg::CFG_IMG_WIDTH:  img_width_reg  <= cfg_data[SW-1:0];
                rckb_pkg::CFG_IMG_HEIGHT: img_height_reg <= cfg_data[SW-1:0];
                rckb_pkg::CFG_ROTATION:   rotation_reg   <= rckb_pkg::rot_t'(cfg_data[1:0]);
                rckb_pkg::CFG_KEY_ENABLE: key_enable_reg <= cfg_data[0];
                rckb_pkg::CFG_KEY_COLOR:  key_color_reg  <= cfg_data[PW-1:0];
                rckb_pkg::CFG_BACK_COLOR: back_color_reg <= cfg_data[PW-1:0];
                rckb_pkg::CFG_DEST_X:     dest_x_reg     <= cfg_data[XW-1:0];
                rckb_pkg::CFG_DEST_Y:     dest_y_reg     <= cfg_data[XW-1:0];
                default: begin
                end
            endcase
        end
    end

    // pixel store: one write port for loads, one registered read for fetches
    always_ff @(posedge aclk) begin
        if (do_load) begin
            mem[load_count_reg[AW-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_fetch) begin
            rd_data_reg <= mem[rd_addr];
            fx_reg      <= dest_x_reg + XW'(out_col_reg);
            fy_reg      <= dest_y_reg + XW'(out_row_reg);
            flast_reg   <= last_px;
        end
    end

    assign pix_keyed = (key_enable_reg && rd_data_reg == key_color_reg) ? back_color_reg
                                                                         : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == rckb_pkg::ST_EMIT && slot_free) begin
            m_pix_reg  <= pix_keyed;
            m_x_reg    <= fx_reg;
            m_y_reg    <= fy_reg;
            m_last_reg <= flast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;

`include "rotating_color_key_blitter_assert.svh"

    `RCKB_ASSERT(a_ready_count, aclk, aresetn, image_ready_reg == (load_count_reg == total))
    `RCKB_ASSERT(a_count_bound, aclk, aresetn, load_count_reg <= total)
    `RCKB_ASSERT(a_scan_bound, aclk, aresetn, out_row_reg <= rows_m1 && out_col_reg <= cols_m1)
    `RCKB_ASSERT_NEXT(a_fetch_emit, aclk, aresetn, do_fetch, state_reg == rckb_pkg::ST_EMIT)
    `RCKB_ASSERT_NEXT(a_last_restart, aclk, aresetn, do_fetch && last_px && !cfg_fire,
        !image_ready_reg && load_count_reg == '0)

endmodule

`default_nettype wire

>>> tb/rotating_color_key_blitter_tb.sv
module rotating_color_key_blitter_tb;
    localparam int PW   = rckb_pkg::PIX_W;
    localparam int XW   = rckb_pkg::SCR_W;
    localparam int SW   = rckb_pkg::SIDE_W;
    localparam int IW   = rckb_pkg::CFG_IDX_W;
    localparam int DW   = rckb_pkg::CFG_DATA_W;
    localparam int SIDE = rckb_pkg::SIDE_MAX;

    typedef struct {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [PW-1:0] color;
        logic          last;
    } screen_pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IW-1:0]         cfg_index = '0;
    logic [DW-1:0]         cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PW-1:0]         s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*XW+PW-1:0]    m_tdata;
    logic                  m_tlast;

    // blitter state as the block should hold it
    logic [PW-1:0]     img_mem [rckb_pkg::MEM_DEPTH];
    int unsigned       n_loaded;
    int unsigned       scan_row;
    int unsigned       scan_col;
    logic              img_full;
    logic [SW-1:0]     reg_w;
    logic [SW-1:0]     reg_h;
    rckb_pkg::rot_t    reg_rot;
    logic              reg_key_en;
    logic [PW-1:0]     reg_key;
    logic [PW-1:0]     reg_back;
    logic [XW-1:0]     reg_dx;
    logic [XW-1:0]     reg_dy;

    screen_pixel_t pixel_queue[$];
    int            err_count = 0;
    bit            pace_on = 1'b1;
    int            hold_cycles = 0;

    rotating_color_key_blitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned side_len(input logic [SW-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > SIDE) begin
            return SIDE;
        end
        return v;
    endfunction

    function automatic void restart_image();
        n_loaded = 0;
        scan_row = 0;
        scan_col = 0;
        img_full = 1'b0;
    endfunction

    function automatic void note_mismatch(input string what, input logic [15:0] got,
                                          input logic [15:0] want);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        screen_pixel_t want;
        int unsigned   w, h, rows, cols, sr, sc;
        logic [15:0]   px;
        if (!aresetn) begin
            restart_image();
            reg_w = SW'(1);
            reg_h = SW'(1);
            reg_rot = rckb_pkg::ROT_0;
            reg_key_en = 1'b0;
            reg_key = '0;
            reg_back = '0;
            reg_dx = '0;
            reg_dy = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_queue.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("%0t unexpected pixel: tdata %h tlast %b", $time, m_tdata,
                                 m_tlast);
                    end
                end else begin
                    want = pixel_queue.pop_front();
                    if (m_tdata[15:0] !== want.x)
                        note_mismatch("screen_x", m_tdata[15:0], want.x);
                    if (m_tdata[31:16] !== want.y)
                        note_mismatch("screen_y", m_tdata[31:16], want.y);
                    if (m_tdata[47:32] !== want.color)
                        note_mismatch("pixel_out", m_tdata[47:32], want.color);
                    if (m_tlast !== want.last)
                        note_mismatch("last_pixel", 16'(m_tlast), 16'(want.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rckb_pkg::CFG_IMG_WIDTH: begin
                        reg_w = cfg_data[SW-1:0];
                        restart_image();
                    end
                    rckb_pkg::CFG_IMG_HEIGHT: begin
                        reg_h = cfg_data[SW-1:0];
                        restart_image();
                    end
                    rckb_pkg::CFG_ROTATION: begin
                        reg_rot = rckb_pkg::rot_t'(cfg_data[rckb_pkg::ROT_W-1:0]);
                        scan_row = 0;
                        scan_col = 0;
                    end
                    rckb_pkg::CFG_KEY_ENABLE: reg_key_en = cfg_data[0];
                    rckb_pkg::CFG_KEY_COLOR:  reg_key = cfg_data;
                    rckb_pkg::CFG_BACK_COLOR: reg_back = cfg_data;
                    rckb_pkg::CFG_DEST_X:     reg_dx = cfg_data;
                    rckb_pkg::CFG_DEST_Y:     reg_dy = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                w = side_len(reg_w);
                h = side_len(reg_h);
                if (s_tuser == rckb_pkg::FUNC_LOAD) begin
                    if (!img_full && n_loaded < w * h) begin
                        img_mem[n_loaded] = s_tdata;
                        n_loaded++;
                        img_full = (n_loaded >= w * h);
                    end
                end else if (img_full) begin
                    // quarter turns swap the output row and column counts
                    if (reg_rot == rckb_pkg::ROT_90 || reg_rot == rckb_pkg::ROT_270) begin
                        rows = w;
                        cols = h;
                    end else begin
                        rows = h;
                        cols = w;
                    end
                    if (scan_row >= rows) scan_row = rows - 1;
                    if (scan_col >= cols) scan_col = cols - 1;
                    case (reg_rot)
                        rckb_pkg::ROT_90: begin
                            sr = h - 1 - scan_col;
                            sc = scan_row;
                        end
                        rckb_pkg::ROT_180: begin
                            sr = h - 1 - scan_row;
                            sc = w - 1 - scan_col;
                        end
                        rckb_pkg::ROT_270: begin
                            sr = scan_col;
                            sc = w - 1 - scan_row;
                        end
                        default: begin
                            sr = scan_row;
                            sc = scan_col;
                        end
                    endcase
                    px = img_mem[sr * w + sc];
                    if (reg_key_en && px == reg_key) px = reg_back;
                    want.x = 16'(reg_dx + scan_col);
                    want.y = 16'(reg_dy + scan_row);
                    want.color = px;
                    want.last = (scan_row == rows - 1) && (scan_col == cols - 1);
                    pixel_queue.push_back(want);
                    if (want.last) begin
                        restart_image();
                    end else if (scan_col + 1 >= cols) begin
                        scan_col = 0;
                        scan_row++;
                    end else begin
                        scan_col++;
                    end
                end
            end
        end
    end

    // result side: random stall per item, plus a long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) stall_left = pace_on ? $urandom_range(0, 3) : 0;
        end
    end

    // valid stays up after an item so back-to-back items need no extra edge
    task automatic send_item(input logic func, input logic [PW-1:0] data);
        int gap;
        gap = pace_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [IW-1:0] idx, input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // extra cycles cover a load still being written into the store
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pixel_queue.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_pixels(input int unsigned count, input logic [PW-1:0] key);
        repeat (count) begin
            if ($urandom_range(0, 19) == 0) send_item(rckb_pkg::FUNC_FETCH, 16'($urandom));
            send_item(rckb_pkg::FUNC_LOAD, ($urandom_range(0, 3) == 0) ? key : 16'($urandom));
        end
    endtask

    task automatic fetch_pixels(input int unsigned count);
        repeat (count) send_item(rckb_pkg::FUNC_FETCH, 16'($urandom));
    endtask

    task automatic test_single_pixel();
        wait_idle();
        send_item(rckb_pkg::FUNC_FETCH, 16'hFFFF);
        send_item(rckb_pkg::FUNC_LOAD, 16'hFFFF);
        send_item(rckb_pkg::FUNC_LOAD, 16'h0000);
        send_item(rckb_pkg::FUNC_FETCH, 16'h0000);
        send_item(rckb_pkg::FUNC_FETCH, 16'hFFFF);
        send_item(rckb_pkg::FUNC_LOAD, 16'h0000);
        send_item(rckb_pkg::FUNC_FETCH, 16'h0000);
    endtask

    task automatic test_rotations();
        logic [PW-1:0] pix [6];
        pix = '{16'hF800, 16'h0000, 16'hFFFF, 16'h1234, 16'hF800, 16'h8001};
        wait_idle();
        cfg_write(rckb_pkg::CFG_IMG_WIDTH, 16'hFE03);
        cfg_write(rckb_pkg::CFG_IMG_HEIGHT, 16'h0002);
        cfg_write(rckb_pkg::CFG_ROTATION, 16'(rckb_pkg::ROT_0));
        cfg_write(rckb_pkg::CFG_KEY_ENABLE, 16'h0001);
        cfg_write(rckb_pkg::CFG_KEY_COLOR, 16'hF800);
        cfg_write(rckb_pkg::CFG_BACK_COLOR, 16'h07E0);
        cfg_write(rckb_pkg::CFG_DEST_X, 16'hFFFE);
        cfg_write(rckb_pkg::CFG_DEST_Y, 16'hFFFF);
        // size write part way through a load starts it over
        send_item(rckb_pkg::FUNC_LOAD, 16'h5555);
        send_item(rckb_pkg::FUNC_LOAD, 16'hAAAA);
        wait_idle();
        cfg_write(rckb_pkg::CFG_IMG_WIDTH, 16'h0003);
        foreach (pix[i]) send_item(rckb_pkg::FUNC_LOAD, pix[i]);
        wait_idle();
        cfg_write(IW'(rckb_pkg::CFG_DEST_Y) + IW'($urandom_range(1, 8)), 16'hFFFF);
        fetch_pixels(2);
        wait_idle();
        cfg_write(rckb_pkg::CFG_ROTATION, 16'(rckb_pkg::ROT_90));
        fetch_pixels(2);
        wait_idle();
        cfg_write(rckb_pkg::CFG_ROTATION, 16'(rckb_pkg::ROT_180));
        fetch_pixels(2);
        wait_idle();
        cfg_write(rckb_pkg::CFG_ROTATION, 16'(rckb_pkg::ROT_270));
        fetch_pixels(6);
    endtask

    // wide image: width above the maximum, height zero
    task automatic test_size_extremes();
        wait_idle();
        cfg_write(rckb_pkg::CFG_IMG_WIDTH, 16'h01FF);
        cfg_write(rckb_pkg::CFG_IMG_HEIGHT, 16'h0000);
        cfg_write(rckb_pkg::CFG_ROTATION, 16'(rckb_pkg::ROT_90));
        cfg_write(rckb_pkg::CFG_KEY_ENABLE, 16'h0000);
        cfg_write(rckb_pkg::CFG_DEST_X, 16'h0000);
        cfg_write(rckb_pkg::CFG_DEST_Y, 16'hFF80);
        load_pixels(SIDE, 16'h0000);
        fetch_pixels(SIDE);
    endtask

    // tall image: width zero, height above the maximum, fetched under a long stall
    task automatic test_backpressure();
        wait_idle();
        cfg_write(rckb_pkg::CFG_IMG_WIDTH, 16'hFE00);
        cfg_write(rckb_pkg::CFG_IMG_HEIGHT, 16'h012C);
        cfg_write(rckb_pkg::CFG_ROTATION, 16'(rckb_pkg::ROT_270));
        cfg_write(rckb_pkg::CFG_KEY_ENABLE, 16'h0001);
        cfg_write(rckb_pkg::CFG_KEY_COLOR, 16'hFFFF);
        cfg_write(rckb_pkg::CFG_BACK_COLOR, 16'h001F);
        cfg_write(rckb_pkg::CFG_DEST_X, 16'hFFFF);
        cfg_write(rckb_pkg::CFG_DEST_Y, 16'h0000);
        load_pixels(SIDE, 16'hFFFF);
        send_item(rckb_pkg::FUNC_LOAD, 16'h1111);
        send_item(rckb_pkg::FUNC_LOAD, 16'h2222);
        hold_cycles = 200;
        fetch_pixels(24);
    endtask

    task automatic test_random_images();
        int unsigned   useful, total, w_val, h_val, k;
        logic [PW-1:0] key;
        useful = 0;
        while (useful < 40) begin
            wait_idle();
            pace_on = ($urandom_range(0, 3) != 0);
            w_val = $urandom_range(0, 5);
            h_val = $urandom_range(0, 5);
            key = 16'($urandom);
            cfg_write(rckb_pkg::CFG_IMG_WIDTH, {7'($urandom), 9'(w_val)});
            cfg_write(rckb_pkg::CFG_IMG_HEIGHT, {7'($urandom), 9'(h_val)});
            cfg_write(rckb_pkg::CFG_ROTATION, 16'($urandom));
            cfg_write(rckb_pkg::CFG_KEY_ENABLE, 16'($urandom));
            cfg_write(rckb_pkg::CFG_KEY_COLOR, key);
            cfg_write(rckb_pkg::CFG_BACK_COLOR, 16'($urandom));
            cfg_write(rckb_pkg::CFG_DEST_X, 16'($urandom));
            cfg_write(rckb_pkg::CFG_DEST_Y, 16'($urandom));
            if ($urandom_range(0, 7) == 0)
                cfg_write(IW'(rckb_pkg::CFG_DEST_Y) + IW'($urandom_range(1, 8)),
                          16'($urandom));
            total = side_len(9'(w_val)) * side_len(9'(h_val));
            // broken load: abandoned by a size write
            if ($urandom_range(0, 7) == 0) begin
                load_pixels($urandom_range(0, total - 1), key);
                wait_idle();
                cfg_write(rckb_pkg::CFG_IMG_WIDTH, {7'($urandom), 9'(w_val)});
            end
            load_pixels(total, key);
            repeat ($urandom_range(0, 2)) send_item(rckb_pkg::FUNC_LOAD, 16'($urandom));
            // rotation change part way through the scan
            if (total > 1 && $urandom_range(0, 3) == 0) begin
                k = $urandom_range(1, total - 1);
                fetch_pixels(k);
                wait_idle();
                cfg_write(rckb_pkg::CFG_ROTATION, 16'($urandom));
            end
            fetch_pixels(total);
            if ($urandom_range(0, 3) == 0) send_item(rckb_pkg::FUNC_FETCH, 16'($urandom));
            useful += 2 * total;
        end
    endtask

    initial begin : main_seq
        int drain;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_single_pixel();
        test_rotations();
        test_size_extremes();
        test_backpressure();
        test_random_images();
        s_tvalid <= 1'b0;
        drain = 0;
        while (pixel_queue.size() != 0 && drain < 1000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (8) @(negedge aclk);
        if (pixel_queue.size() != 0) begin
            err_count += pixel_queue.size();
            $display("%0d expected pixels never arrived", pixel_queue.size());
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for the blitter");
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/rckb_pkg.sv
hdl/rotating_color_key_blitter.sv
tb/rotating_color_key_blitter_tb.sv
